// ===== hdl/cmbp_pkg.sv =====
// Shared types, codes and constants of the CoAP message byte parser.
package cmbp_pkg;

	localparam int unsigned MaxTokenBytes = 8;
	localparam int unsigned DefQueueDepth = 2;
	localparam logic [15:0] Block2Option = 16'd23;
	localparam logic [7:0]  PayloadMarker = 8'hff;
	localparam logic [3:0]  BlockExpBias = 4'd4;

	typedef enum logic [2:0] {
		CLS_HEADER   = 3'd0,
		CLS_TOKEN    = 3'd1,
		CLS_OPTHDR   = 3'd2,
		CLS_OPTVAL   = 3'd3,
		CLS_MARKER   = 3'd4,
		CLS_PAYLOAD  = 3'd5,
		CLS_IGNORED  = 3'd6
	} byte_class_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_SHORT     = 2'd1,
		ERR_TOKEN     = 2'd2,
		ERR_TRUNCATED = 2'd3
	} error_t;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_TOKEN,
		PH_OPTHDR,
		PH_OPTVAL,
		PH_PAYLOAD,
		PH_IGNORE
	} phase_t;

	typedef struct packed {
		logic [3:0] number;
		logic       more;
		logic [3:0] size_exp;
	} block_t;

	// Byte as classified by the front part, ready for the parser.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       is_marker;
		logic       is_zero;
		block_t     block;
	} item_t;

	typedef struct packed {
		byte_class_t cls;
		logic [1:0]  version;
		logic [1:0]  msg_type;
		logic [3:0]  token_length;
		logic [7:0]  code;
		logic [15:0] message_id;
		logic [15:0] option_number;
		logic [3:0]  option_length;
		error_t      error_code;
		block_t      block;
	} result_t;

	// Queue status seen by the back part.
	typedef struct packed {
		logic  valid;
		item_t head;
	} queue_head_t;

endpackage

// ===== hdl/coap_message_byte_parser_unit.sv =====
// Top level of the CoAP message byte parser.
// Takes a CoAP datagram one byte per request (last_byte marks the final byte) and
// returns one result per byte: its class (header, token, option header, option
// value, payload marker, payload or ignored) together with the header fields,
// running option number and length, error code and decoded one-byte Block2 value,
// all as they stand after that byte. The parser returns to its reset state after
// the marked byte. Sustained rate is one byte per clock cycle while out_stall is
// low; the result of a byte passes through the front register, the queue and the
// result register in that order and is held while out_stall holds. The parse state
// lives in the back part and is updated once per byte, which is what sets the
// one-byte-per-cycle figure. The front register and the QUEUE_DEPTH-entry queue let
// the input keep flowing for a few bytes while the result side is stalled.
module coap_message_byte_parser_unit #(
	parameter int unsigned QUEUE_DEPTH = cmbp_pkg::DefQueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  byte_class,
	output logic [1:0]  version,
	output logic [1:0]  msg_type,
	output logic [3:0]  token_length,
	output logic [7:0]  code,
	output logic [15:0] message_id,
	output logic [15:0] option_number,
	output logic [3:0]  option_length,
	output logic [1:0]  error_code,
	output logic [3:0]  block_number,
	output logic        block_more,
	output logic [3:0]  block_size_exp
);
	import cmbp_pkg::*;

	item_t       push_item;
	logic        push;
	logic        q_full;
	logic        pop;
	queue_head_t head;
	result_t     result;

	// Register and classify bytes; hold the request while a byte waits on a full queue
	cmbp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	// Decouple the two sides
	cmbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	// Advance the parse and present the result
	cmbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.result    (result)
	);

	assign byte_class     = result.cls;
	assign version        = result.version;
	assign msg_type       = result.msg_type;
	assign token_length   = result.token_length;
	assign code           = result.code;
	assign message_id     = result.message_id;
	assign option_number  = result.option_number;
	assign option_length  = result.option_length;
	assign error_code     = result.error_code;
	assign block_number   = result.block.number;
	assign block_more     = result.block.more;
	assign block_size_exp = result.block.size_exp;

endmodule

// ===== hdl/cmbp_front.sv =====
// Front part: register each request and classify its byte.
module cmbp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  logic [7:0]      data_byte,
	input  logic            last_byte,
	input  logic            q_full,
	output logic            push,
	output cmbp_pkg::item_t push_item
);
	import cmbp_pkg::*;

	item_t item_s1;
	logic  valid_s1;
	logic  accept;

	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;
	assign push     = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.data           <= data_byte;
			item_s1.last           <= last_byte;
			item_s1.is_marker      <= (data_byte == PayloadMarker);
			item_s1.is_zero        <= (data_byte == 8'h00);
			item_s1.block.number   <= data_byte[7:4];
			item_s1.block.more     <= data_byte[3];
			item_s1.block.size_exp <= {1'b0, data_byte[2:0]} + BlockExpBias;
		end
	end

endmodule

// ===== hdl/cmbp_queue.sv =====
// Short request queue between the front and back parts.
module cmbp_queue #(
	parameter int unsigned DEPTH = cmbp_pkg::DefQueueDepth
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  cmbp_pkg::item_t       push_item,
	output logic                  full,
	input  logic                  pop,
	output cmbp_pkg::queue_head_t head
);
	import cmbp_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	item_t             entry_q [DEPTH];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntW-1:0]   count_q;
	logic              do_push;
	logic              do_pop;

	assign full       = (count_q == CntW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.head  = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/cmbp_back.sv =====
// Back part: datagram parse state and the result register.
module cmbp_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmbp_pkg::queue_head_t head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output cmbp_pkg::result_t     result
);
	import cmbp_pkg::*;

	phase_t      phase_q, phase_n;
	logic [1:0]  hcnt_q, hcnt_n;
	logic [3:0]  left_q, left_n;
	logic [15:0] sum_q, sum_n;
	logic [3:0]  len_q, len_n;
	logic [7:0]  hdr0_q, hdr0_n;
	logic [7:0]  code_q, code_n;
	logic [15:0] mid_q, mid_n;
	error_t      err_q, err_n, err_hdr;
	block_t      blk_q, blk_n;
	byte_class_t cls;
	logic        out_valid_q;
	result_t     result_q;
	item_t       it;

	assign it        = head.head;
	assign pop       = head.valid && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// Next state
	always_comb begin
		phase_n = phase_q;
		hcnt_n  = hcnt_q;
		left_n  = left_q;
		sum_n   = sum_q;
		len_n   = len_q;
		hdr0_n  = hdr0_q;
		code_n  = code_q;
		mid_n   = mid_q;
		blk_n   = blk_q;
		err_hdr = err_q;
		case (phase_q)
			PH_HEADER: begin
				case (hcnt_q)
					2'd0: hdr0_n = it.data;
					2'd1: code_n = it.data;
					2'd2: mid_n  = {it.data, 8'h00};
					default: begin
						mid_n[7:0] = it.data;
						if (hdr0_q[3:0] > 4'(MaxTokenBytes)) begin
							if (err_q == ERR_NONE) begin
								err_hdr = ERR_TOKEN;
							end
							phase_n = PH_IGNORE;
						end else if (hdr0_q[3:0] == 4'd0) begin
							phase_n = PH_OPTHDR;
						end else begin
							left_n  = hdr0_q[3:0];
							phase_n = PH_TOKEN;
						end
					end
				endcase
				if (hcnt_q != 2'd3) begin
					hcnt_n = hcnt_q + 2'd1;
				end
			end
			PH_TOKEN: begin
				left_n = left_q - 4'd1;
				if (left_n == 4'd0) begin
					phase_n = PH_OPTHDR;
				end
			end
			PH_OPTHDR: begin
				if (it.is_marker) begin
					phase_n = PH_PAYLOAD;
				end else if (it.is_zero) begin
					phase_n = PH_IGNORE;
				end else begin
					sum_n = sum_q + {12'd0, it.data[7:4]};
					len_n = it.data[3:0];
					if (it.data[3:0] != 4'd0) begin
						left_n  = it.data[3:0];
						phase_n = PH_OPTVAL;
					end
				end
			end
			PH_OPTVAL: begin
				if (sum_q == Block2Option && len_q == 4'd1) begin
					blk_n = it.block;
				end
				left_n = left_q - 4'd1;
				if (left_n == 4'd0) begin
					phase_n = PH_OPTHDR;
				end
			end
			default: begin
			end
		endcase
		// first error wins; end of datagram checks the phase it leaves in
		err_n = err_hdr;
		if (it.last && err_hdr == ERR_NONE) begin
			if (phase_n == PH_HEADER) begin
				err_n = ERR_SHORT;
			end else if (phase_n == PH_TOKEN || phase_n == PH_OPTVAL) begin
				err_n = ERR_TRUNCATED;
			end
		end
	end

	// Byte class
	always_comb begin
		case (phase_q)
			PH_HEADER:  cls = CLS_HEADER;
			PH_TOKEN:   cls = CLS_TOKEN;
			PH_OPTHDR: begin
				if (it.is_marker) begin
					cls = CLS_MARKER;
				end else if (it.is_zero) begin
					cls = CLS_IGNORED;
				end else begin
					cls = CLS_OPTHDR;
				end
			end
			PH_OPTVAL:  cls = CLS_OPTVAL;
			PH_PAYLOAD: cls = CLS_PAYLOAD;
			default:    cls = CLS_IGNORED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hcnt_q      <= '0;
			left_q      <= '0;
			sum_q       <= '0;
			len_q       <= '0;
			hdr0_q      <= '0;
			code_q      <= '0;
			mid_q       <= '0;
			err_q       <= ERR_NONE;
			blk_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (it.last) begin
					phase_q <= PH_HEADER;
					hcnt_q  <= '0;
					left_q  <= '0;
					sum_q   <= '0;
					len_q   <= '0;
					hdr0_q  <= '0;
					code_q  <= '0;
					mid_q   <= '0;
					err_q   <= ERR_NONE;
					blk_q   <= '0;
				end else begin
					phase_q <= phase_n;
					hcnt_q  <= hcnt_n;
					left_q  <= left_n;
					sum_q   <= sum_n;
					len_q   <= len_n;
					hdr0_q  <= hdr0_n;
					code_q  <= code_n;
					mid_q   <= mid_n;
					err_q   <= err_n;
					blk_q   <= blk_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			result_q.cls           <= cls;
			result_q.version       <= hdr0_n[7:6];
			result_q.msg_type      <= hdr0_n[5:4];
			result_q.token_length  <= hdr0_n[3:0];
			result_q.code          <= code_n;
			result_q.message_id    <= mid_n;
			result_q.option_number <= sum_n;
			result_q.option_length <= len_n;
			result_q.error_code    <= err_n;
			result_q.block         <= blk_n;
		end
	end

endmodule

// ===== hdl/cmbp_checker.sv =====
// Port-level checks of the CoAP message byte parser, bound to its top level.
module cmbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  byte_class,
	input logic [3:0]  token_length,
	input logic [15:0] option_number,
	input logic [3:0]  option_length,
	input logic [3:0]  block_size_exp
);
	import cmbp_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(byte_class) && $stable(option_number))
		else $error("stalled result changed");

	// a decoded Block2 size exponent is always biased by four
	a_block_exp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && block_size_exp != 4'd0 |-> block_size_exp >= BlockExpBias)
		else $error("block size exponent out of range");

	// token bytes only follow a legal non-zero token length
	a_token: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_class == CLS_TOKEN |->
			token_length != 4'd0 && token_length <= 4'(MaxTokenBytes))
		else $error("token byte with illegal token length");

	// option value bytes only follow an option of non-zero length
	a_optval: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_class == CLS_OPTVAL |-> option_length != 4'd0)
		else $error("option value byte with zero option length");

endmodule

bind coap_message_byte_parser_unit cmbp_checker u_cmbp_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.byte_class     (byte_class),
	.token_length   (token_length),
	.option_number  (option_number),
	.option_length  (option_length),
	.block_size_exp (block_size_exp)
);
